### sv/rcst_pkg.sv
// Package for the register constant store tracker: instruction codes, item and
// result types, and the write-port bundle of the value store. No dependencies.
`default_nettype none

package rcst_pkg;

  localparam int NUM_REGS = 32;
  localparam int REG_W    = 5;
  localparam int VAL_W    = 32;
  localparam int IMM_W    = 16;

  // Registers cleared by a linking branch (the volatile argument registers).
  localparam int VOL_LO = 3;
  localparam int VOL_HI = 12;

  // Register that aliases the incoming object pointer at the start of a body.
  localparam int OBJ_REG = 3;
  localparam logic [NUM_REGS-1:0] ALIAS_RESET = NUM_REGS'(1) << OBJ_REG;

  typedef enum logic [2:0] {
    OP_ADDIS  = 3'd0,
    OP_ADDI   = 3'd1,
    OP_ORI    = 3'd2,
    OP_OR     = 3'd3,
    OP_STW    = 3'd4,
    OP_BRANCH = 3'd5,
    OP_OTHER  = 3'd6
  } op_t;

  typedef struct packed {
    logic [2:0]              operation;
    logic                    link_bit;
    logic [REG_W-1:0]        reg_d;
    logic [REG_W-1:0]        reg_a;
    logic [REG_W-1:0]        reg_s;
    logic [REG_W-1:0]        reg_b;
    logic signed [IMM_W-1:0] signed_imm;
    logic [IMM_W-1:0]        unsigned_imm;
    logic signed [IMM_W-1:0] store_disp;
    logic                    start_req;
    logic                    last;
  } rcst_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] found_pointer;
    logic             final_res;
  } rcst_result_t;

  typedef struct packed {
    logic             en;
    logic [REG_W-1:0] addr;
    logic [VAL_W-1:0] data;
  } rcst_wr_t;

endpackage

`default_nettype wire

### sv/rcst_stream_if.sv
// Valid/ready stream interface used for both the item and the result channel.
// The payload type is a parameter; no package dependency.
`default_nettype none

interface rcst_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/register_constant_store_tracker_top.sv
// Register constant store tracker, top level. Depends on rcst_pkg,
// rcst_stream_if and rcst_regfile.
//
// The block scans a stream of pre-decoded PowerPC instructions, one item per
// instruction, and tracks for each of the 32 general registers whether it holds
// a known 32-bit constant and whether it aliases the incoming object pointer
// (register 3 at the start of a body). A word store at displacement zero through
// an alias register, whose stored register holds a known constant, records that
// constant as the found pointer; the last such store wins. Every item yields one
// result carrying the current found pointer and a copy of its last flag. An item
// with start_req set first returns all tracking to its initial state. The block
// accepts one item per clock cycle unless the result channel stalls it: the
// register values are read from the value store on acceptance, and the update
// of the flags, the value store and the found pointer happens when the item
// leaves the execute stage, together with the loading of the result register.
// A write and a read of the same register on one edge are bypassed, so
// dependent instructions may follow each other directly. Backpressure on the
// result channel stalls the input only when both internal stages are full.
`default_nettype none

module register_constant_store_tracker_top
  import rcst_pkg::*;
(
  input wire logic   clk,
  input wire logic   rst,
  rcst_stream_if.sink   item_in,
  rcst_stream_if.source result_out
);

  // Execute stage holding one accepted item.
  rcst_item_t s1_item;
  logic       s1_v;

  // Result register.
  rcst_result_t res;
  logic         res_v;

  // Tracking state. Constant values live in the value store.
  logic [NUM_REGS-1:0] known;
  logic [NUM_REGS-1:0] alias_flag;
  logic [VAL_W-1:0]    pointer_found;

  logic [NUM_REGS-1:0] known_next;
  logic [NUM_REGS-1:0] alias_next;
  logic [VAL_W-1:0]    pointer_next;

  logic [VAL_W-1:0] val_a;
  logic [VAL_W-1:0] val_s;
  rcst_wr_t         wr;
  rcst_wr_t         wr_c;

  logic adv;
  logic s1_fire;
  logic accept;

  assign adv     = !res_v || result_out.ready;
  assign s1_fire = s1_v && adv;
  assign accept  = item_in.valid && item_in.ready;

  assign item_in.ready    = !s1_v || adv;
  assign result_out.valid = res_v;
  assign result_out.data  = res;

  rcst_regfile u_regfile (
    .clk       (clk),
    .rd_en     (accept),
    .rd_addr_a (item_in.data.reg_a),
    .rd_addr_s (item_in.data.reg_s),
    .wr        (wr),
    .rd_data_a (val_a),
    .rd_data_s (val_s)
  );

  // Update of the tracking state for the item in the execute stage. A start
  // item works on the initial state; stale store values are harmless because
  // every known flag is cleared then.
  always_comb begin
    logic [NUM_REGS-1:0] k_cur;
    logic [NUM_REGS-1:0] a_cur;
    logic [VAL_W-1:0]    p_cur;
    logic [VAL_W-1:0]    addend;
    logic                src_ok;

    k_cur  = s1_item.start_req ? '0 : known;
    a_cur  = s1_item.start_req ? ALIAS_RESET : alias_flag;
    p_cur  = s1_item.start_req ? '0 : pointer_found;
    addend = '0;
    src_ok = 1'b0;

    known_next   = k_cur;
    alias_next   = a_cur;
    pointer_next = p_cur;
    wr_c         = '0;

    case (s1_item.operation)
      OP_ADDIS, OP_ADDI: begin
        if (s1_item.operation == OP_ADDIS) begin
          addend = {s1_item.signed_imm, {IMM_W{1'b0}}};
        end else begin
          addend = VAL_W'(s1_item.signed_imm);
        end
        src_ok = (s1_item.reg_a == '0) || k_cur[s1_item.reg_a];
        known_next[s1_item.reg_d] = src_ok;
        wr_c.en   = src_ok;
        wr_c.addr = s1_item.reg_d;
        wr_c.data = (s1_item.reg_a == '0) ? addend : val_a + addend;
        // A move through addi with zero immediate carries the alias along.
        alias_next[s1_item.reg_d] = (s1_item.operation == OP_ADDI)
                                 && (s1_item.reg_a != '0)
                                 && (s1_item.signed_imm == '0)
                                 && a_cur[s1_item.reg_a];
      end
      OP_ORI: begin
        known_next[s1_item.reg_a] = k_cur[s1_item.reg_s];
        alias_next[s1_item.reg_a] = 1'b0;
        wr_c.en   = k_cur[s1_item.reg_s];
        wr_c.addr = s1_item.reg_a;
        wr_c.data = val_s | VAL_W'(s1_item.unsigned_imm);
      end
      OP_OR: begin
        if (s1_item.reg_s == s1_item.reg_b) begin
          // Register move.
          known_next[s1_item.reg_a] = k_cur[s1_item.reg_s];
          alias_next[s1_item.reg_a] = a_cur[s1_item.reg_s];
          wr_c.en   = k_cur[s1_item.reg_s];
          wr_c.addr = s1_item.reg_a;
          wr_c.data = val_s;
        end else begin
          known_next[s1_item.reg_a] = 1'b0;
          alias_next[s1_item.reg_a] = 1'b0;
        end
      end
      OP_STW: begin
        if (s1_item.store_disp == '0 && a_cur[s1_item.reg_a] && k_cur[s1_item.reg_s]) begin
          pointer_next = val_s;
        end
      end
      OP_BRANCH: begin
        if (s1_item.link_bit) begin
          known_next[VOL_HI:VOL_LO] = '0;
          alias_next[VOL_HI:VOL_LO] = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    wr    = wr_c;
    wr.en = wr_c.en && s1_fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v          <= 1'b0;
      res_v         <= 1'b0;
      known         <= '0;
      alias_flag    <= ALIAS_RESET;
      pointer_found <= '0;
    end else begin
      if (accept) begin
        s1_v <= 1'b1;
      end else if (s1_fire) begin
        s1_v <= 1'b0;
      end
      if (s1_fire) begin
        res_v         <= 1'b1;
        known         <= known_next;
        alias_flag    <= alias_next;
        pointer_found <= pointer_next;
      end else if (result_out.ready) begin
        res_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item_in.data;
    end
    if (s1_fire) begin
      res.found_pointer <= pointer_next;
      res.final_res     <= s1_item.last;
    end
  end

  // The value store is written only by an item leaving the execute stage.
  a_wr_on_fire: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> s1_fire)
    else $error("value store written without an item leaving execute");

  // Only a store can change the found pointer of a continuing body.
  a_ptr_only_stw: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && !s1_item.start_req && s1_item.operation != OP_STW)
      |=> $stable(pointer_found))
    else $error("found pointer changed by a non-store item");

  // A call leaves no volatile register known or aliased.
  a_call_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_item.operation == OP_BRANCH && s1_item.link_bit)
      |=> (known[VOL_HI:VOL_LO] == '0 && alias_flag[VOL_HI:VOL_LO] == '0))
    else $error("linking branch left volatile registers tracked");

  // A start item with no register effect leaves exactly the initial state.
  a_start_state: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_item.start_req && s1_item.operation == OP_OTHER)
      |=> (known == '0 && alias_flag == ALIAS_RESET && pointer_found == '0))
    else $error("start item did not restore the initial tracking state");

  // The result register follows the execute stage in the next cycle.
  a_res_follows: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> (res_v && res.found_pointer == pointer_found))
    else $error("result register does not show the updated found pointer");

endmodule

`default_nettype wire

### sv/rcst_regfile.sv
// Value store of the tracker: 32 x 32-bit memory, one write port and two
// registered read ports with write-first bypass. Depends on rcst_pkg.
`default_nettype none

module rcst_regfile
  import rcst_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [REG_W-1:0] rd_addr_a,
  input  wire logic [REG_W-1:0] rd_addr_s,
  input  wire rcst_wr_t         wr,
  output      logic [VAL_W-1:0] rd_data_a,
  output      logic [VAL_W-1:0] rd_data_s
);

  logic [VAL_W-1:0] mem [NUM_REGS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // A write landing on the same edge as the read is passed straight through.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= (wr.en && wr.addr == rd_addr_a) ? wr.data : mem[rd_addr_a];
      rd_data_s <= (wr.en && wr.addr == rd_addr_s) ? wr.data : mem[rd_addr_s];
    end
  end

endmodule

`default_nettype wire

### sim/register_constant_store_tracker_top_test.sv
// Testbench for register_constant_store_tracker_top: a directed table, then random
// instruction bodies checked against a behavioral tracker of the register state.
// Depends on rcst_pkg, rcst_stream_if and the RTL of the block.
`timescale 1ns / 1ps

module register_constant_store_tracker_top_test;
  import rcst_pkg::*;

  // Opcode value 7 has no name in the package. The block must treat it like any
  // other op that leaves the state alone.
  localparam logic [2:0] OP_UNDEFINED = 3'd7;

  // The result comes out through the execute stage and the result register, so a short drain is plenty.
  localparam int DRAIN_CYCLES = 8;
  // About 650 items, with room for heavy idling.
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int RANDOM_PER_PHASE = 150;
  localparam int NUM_PHASES = 4;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rcst_stream_if #(.T(rcst_item_t))   item_ch ();
  rcst_stream_if #(.T(rcst_result_t)) result_ch ();

  register_constant_store_tracker_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_ch),
    .result_out (result_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Every input of the block has a known value from time zero on.
  initial begin
    item_ch.valid   = 1'b0;
    item_ch.data    = '0;
    result_ch.ready = 1'b0;
  end

  // The idling of each side is set per phase. The first phase runs without any
  // gaps, then the sender idles alone, then the receiver stalls alone, and the
  // last phase mixes both at a lighter rate.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int send_idle_of_phase  [NUM_PHASES] = '{0, 63, 0, 22};
  int recv_stall_of_phase [NUM_PHASES] = '{0, 0, 63, 22};

  int mismatch_count = 0;
  int unsigned cycle_count;

  // Our own view of the register tracking. It is updated on every accepted
  // item, in the order of acceptance, so it always matches the block's state
  // as of the last item handed over.
  logic [VAL_W-1:0]    reg_value [NUM_REGS];
  logic [NUM_REGS-1:0] reg_known;
  logic [NUM_REGS-1:0] reg_alias;
  logic [VAL_W-1:0]    found_ptr;

  // Results that the block still owes us, oldest first.
  rcst_result_t pending_results[$];

  // One row of the directed table. Where the answer is obvious it is written
  // into the row; otherwise the tracker supplies it.
  typedef struct {
    rcst_item_t   instr;
    bit           fixed;
    rcst_result_t fixed_res;
  } directed_row_t;

  directed_row_t directed_rows[$];

  // Appends one row at the end of the directed table.
  function automatic void add_row(rcst_item_t instr, bit fixed, rcst_result_t fixed_res);
    directed_row_t row;
    row.instr     = instr;
    row.fixed     = fixed;
    row.fixed_res = fixed_res;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic void clear_tracking();
    for (int r = 0; r < NUM_REGS; r++) begin
      reg_value[r] = '0;
    end
    reg_known = '0;
    reg_alias = '0;
    reg_alias[OBJ_REG] = 1'b1;
    found_ptr = '0;
  endfunction

  // Applies one instruction to the tracked state and returns the result that
  // the block must produce for it.
  function automatic rcst_result_t track_instruction(rcst_item_t it);
    logic [VAL_W-1:0] addend;
    bit               copy_alias;
    rcst_result_t     res;
    if (it.start_req) begin
      clear_tracking();
    end
    case (it.operation)
      OP_ADDIS, OP_ADDI: begin
        if (it.operation == OP_ADDIS) begin
          addend = {it.signed_imm, 16'h0000};
        end else begin
          addend = {{16{it.signed_imm[IMM_W-1]}}, it.signed_imm};
        end
        // Only addi rD,rA,0 copies the alias, and only from a real register.
        // The flag of rA is read before rD is written, as rD may equal rA.
        copy_alias = (it.operation == OP_ADDI) && (it.reg_a != 0) &&
                     (it.signed_imm == 0) && reg_alias[it.reg_a];
        if (it.reg_a == 0) begin
          reg_value[it.reg_d] = addend;
          reg_known[it.reg_d] = 1'b1;
        end else if (reg_known[it.reg_a]) begin
          reg_value[it.reg_d] = reg_value[it.reg_a] + addend;
          reg_known[it.reg_d] = 1'b1;
        end else begin
          reg_known[it.reg_d] = 1'b0;
        end
        reg_alias[it.reg_d] = copy_alias;
      end
      OP_ORI: begin
        if (reg_known[it.reg_s]) begin
          reg_value[it.reg_a] = reg_value[it.reg_s] | it.unsigned_imm;
          reg_known[it.reg_a] = 1'b1;
        end else begin
          reg_known[it.reg_a] = 1'b0;
        end
        reg_alias[it.reg_a] = 1'b0;
      end
      OP_OR: begin
        // Only the register move form (rS equal to rB) carries anything over.
        if (it.reg_s == it.reg_b) begin
          reg_alias[it.reg_a] = reg_alias[it.reg_s];
          if (reg_known[it.reg_s]) begin
            reg_value[it.reg_a] = reg_value[it.reg_s];
            reg_known[it.reg_a] = 1'b1;
          end else begin
            reg_known[it.reg_a] = 1'b0;
          end
        end else begin
          reg_alias[it.reg_a] = 1'b0;
          reg_known[it.reg_a] = 1'b0;
        end
      end
      OP_STW: begin
        if (it.store_disp == 0 && reg_alias[it.reg_a] && reg_known[it.reg_s]) begin
          found_ptr = reg_value[it.reg_s];
        end
      end
      OP_BRANCH: begin
        // A call clobbers the volatile registers.
        if (it.link_bit) begin
          for (int r = VOL_LO; r <= VOL_HI; r++) begin
            reg_known[r] = 1'b0;
            reg_alias[r] = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
    res.found_pointer = found_ptr;
    res.final_res     = it.last;
    return res;
  endfunction

  function automatic rcst_item_t mk_instr(logic [2:0] op, bit link, int d, int a, int s,
                                          int b, logic [15:0] simm, logic [15:0] uimm,
                                          logic [15:0] disp, bit start, bit last);
    rcst_item_t it;
    it.operation    = op;
    it.link_bit     = link;
    it.reg_d        = REG_W'(d);
    it.reg_a        = REG_W'(a);
    it.reg_s        = REG_W'(s);
    it.reg_b        = REG_W'(b);
    it.signed_imm   = simm;
    it.unsigned_imm = uimm;
    it.store_disp   = disp;
    it.start_req    = start;
    it.last         = last;
    return it;
  endfunction

  // Register choice for random items. Most picks fall on the volatile range,
  // which holds the object register and is what calls clobber, so that
  // constants and aliases built up by one item are often used by the next.
  function automatic logic [REG_W-1:0] pick_reg();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return REG_W'($urandom_range(VOL_HI, VOL_LO));
      5, 6:          return REG_W'($urandom_range(16, 13));
      default:       return REG_W'($urandom_range(NUM_REGS - 1));
    endcase
  endfunction

  // A random instruction. Every field starts out fully random, so unused
  // fields toggle too; most items are then shaped into the patterns the
  // tracker follows: loading constants, copying the object pointer and
  // storing through it. The remainder stays raw noise, including opcode 7.
  function automatic rcst_item_t random_instr(bit first_of_body, bit end_of_body);
    rcst_item_t  it;
    int unsigned pick;
    it.operation    = 3'($urandom_range(7));
    it.link_bit     = 1'($urandom_range(1));
    it.reg_d        = REG_W'($urandom_range(NUM_REGS - 1));
    it.reg_a        = REG_W'($urandom_range(NUM_REGS - 1));
    it.reg_s        = REG_W'($urandom_range(NUM_REGS - 1));
    it.reg_b        = REG_W'($urandom_range(NUM_REGS - 1));
    it.signed_imm   = IMM_W'($urandom);
    it.unsigned_imm = IMM_W'($urandom);
    it.store_disp   = IMM_W'($urandom);
    it.start_req    = first_of_body || ($urandom_range(49) == 0);
    it.last         = end_of_body || ($urandom_range(49) == 0);
    pick = $urandom_range(99);
    if (pick < 20) begin
      // Mostly lis, sometimes an addis on top of another register.
      it.operation = OP_ADDIS;
      it.reg_d     = pick_reg();
      it.reg_a     = ($urandom_range(3) == 0) ? pick_reg() : '0;
    end else if (pick < 35) begin
      // li, addi on a register, or the alias copy addi rD,rA,0.
      it.operation = OP_ADDI;
      it.reg_d     = pick_reg();
      it.reg_a     = ($urandom_range(2) == 0) ? '0 : pick_reg();
      if ($urandom_range(1) == 0) begin
        it.signed_imm = '0;
      end
    end else if (pick < 45) begin
      it.operation = OP_ORI;
      it.reg_a     = pick_reg();
      it.reg_s     = pick_reg();
    end else if (pick < 55) begin
      it.operation = OP_OR;
      it.reg_a     = pick_reg();
      it.reg_s     = pick_reg();
      it.reg_b     = ($urandom_range(3) == 0) ? pick_reg() : it.reg_s;
    end else if (pick < 80) begin
      it.operation = OP_STW;
      it.reg_a     = pick_reg();
      it.reg_s     = pick_reg();
      if ($urandom_range(6) != 0) begin
        it.store_disp = '0;
      end
    end else if (pick < 85) begin
      it.operation = OP_BRANCH;
    end
    return it;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] %s: expected %h, got %h", $time, what, want, got);
    end
  endtask

  // Hands one item to the block. The tracker is advanced only once the item
  // is accepted, so the store of pending results keeps acceptance order. Valid
  // stays high between back-to-back items; it is lowered only for a gap.
  task automatic send_instr(rcst_item_t it, bit fixed, rcst_result_t fixed_res);
    rcst_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= it;
    do @(posedge clk); while (!item_ch.ready);
    predicted = track_instruction(it);
    pending_results.insert(pending_results.size(), fixed ? fixed_res : predicted);
  endtask

  // The receiver decides afresh at every edge whether it takes a result.
  always @(posedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Results are sampled at the edge that accepts them, before any of this
  // step's updates land, and compared with the oldest pending one.
  always @(posedge clk) begin : check_results
    rcst_result_t want;
    rcst_result_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = result_ch.data;
      if (pending_results.size() == 0) begin
        note_mismatch("result with none pending, found_pointer", '0, got.found_pointer);
      end else begin
        want = pending_results.pop_front();
        if (got.found_pointer !== want.found_pointer) begin
          note_mismatch("found_pointer", want.found_pointer, got.found_pointer);
        end
        if (got.final_res !== want.final_res) begin
          note_mismatch("final_res", 32'(want.final_res), 32'(got.final_res));
        end
      end
    end
  end

  // A run that hangs ends here.
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) begin
      @(posedge clk);
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int body_len;
    int sent;
    clear_tracking();

    // Directed part, read top to bottom as one instruction body. Right after
    // reset only the object register aliases the object and nothing is found.
    add_row(mk_instr(OP_OTHER, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0),
            1'b1, '{found_pointer: 32'h0, final_res: 1'b0});
    // lis r5,0x8000 and ori r5,r5,0xffff build a constant at the field extremes.
    add_row(mk_instr(OP_ADDIS, 0, 5, 0, 0, 0, 16'h8000, 0, 0, 0, 0),
            1'b1, '{found_pointer: 32'h0, final_res: 1'b0});
    add_row(mk_instr(OP_ORI, 0, 0, 5, 5, 0, 0, 16'hFFFF, 0, 0, 0),
            1'b1, '{found_pointer: 32'h0, final_res: 1'b0});
    // stw r5,0(r3) records the constant.
    add_row(mk_instr(OP_STW, 0, 0, 3, 5, 0, 0, 0, 0, 0, 0),
            1'b1, '{found_pointer: 32'h8000FFFF, final_res: 1'b0});
    // li r6,-1, then stores at the two extreme nonzero displacements do nothing.
    add_row(mk_instr(OP_ADDI, 0, 6, 0, 0, 0, 16'hFFFF, 0, 0, 0, 0),
            1'b1, '{found_pointer: 32'h8000FFFF, final_res: 1'b0});
    add_row(mk_instr(OP_STW, 0, 0, 3, 6, 0, 0, 0, 16'h8000, 0, 0),
            1'b1, '{found_pointer: 32'h8000FFFF, final_res: 1'b0});
    add_row(mk_instr(OP_STW, 0, 0, 3, 6, 0, 0, 0, 16'h7FFF, 0, 0),
            1'b1, '{found_pointer: 32'h8000FFFF, final_res: 1'b0});
    // addi r7,r3,0 copies the alias, and a store through the copy counts.
    add_row(mk_instr(OP_ADDI, 0, 7, 3, 0, 0, 0, 0, 0, 0, 0),
            1'b0, '{default: '0});
    add_row(mk_instr(OP_STW, 0, 0, 7, 6, 0, 0, 0, 0, 0, 0),
            1'b1, '{found_pointer: 32'hFFFFFFFF, final_res: 1'b0});
    // mr r8,r7 copies it again; addis on -1 wraps around 32 bits.
    add_row(mk_instr(OP_OR, 0, 0, 8, 7, 7, 0, 0, 0, 0, 0),
            1'b0, '{default: '0});
    add_row(mk_instr(OP_ADDIS, 0, 9, 6, 0, 0, 16'h7FFF, 0, 0, 0, 0),
            1'b0, '{default: '0});
    add_row(mk_instr(OP_STW, 0, 0, 8, 9, 0, 0, 0, 0, 0, 0),
            1'b0, '{default: '0});
    // A true or of two different registers makes the target unknown.
    add_row(mk_instr(OP_OR, 0, 0, 10, 6, 9, 0, 0, 0, 0, 0),
            1'b0, '{default: '0});
    add_row(mk_instr(OP_STW, 0, 0, 3, 10, 0, 0, 0, 0, 0, 0),
            1'b0, '{default: '0});
    // r31 is outside the volatile range and survives calls.
    add_row(mk_instr(OP_ADDI, 0, 31, 0, 0, 0, 16'h7FFF, 0, 0, 0, 0),
            1'b0, '{default: '0});
    // A branch without link keeps all tracking, so the store through r7 works.
    add_row(mk_instr(OP_BRANCH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
            1'b0, '{default: '0});
    add_row(mk_instr(OP_STW, 0, 0, 7, 31, 0, 0, 0, 0, 0, 0),
            1'b0, '{default: '0});
    // A call wipes r3 to r12, after which r3 no longer aliases the object.
    add_row(mk_instr(OP_BRANCH, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0),
            1'b0, '{default: '0});
    add_row(mk_instr(OP_STW, 0, 0, 3, 31, 0, 0, 0, 0, 0, 0),
            1'b0, '{default: '0});
    add_row(mk_instr(OP_UNDEFINED, 1, 31, 31, 31, 31, 16'hFFFF, 16'hFFFF,
                     16'hFFFF, 0, 0), 1'b0, '{default: '0});
    // addi from an unknown register leaves the target unknown.
    add_row(mk_instr(OP_ADDI, 0, 4, 13, 0, 0, 16'h0005, 0, 0, 0, 0),
            1'b0, '{default: '0});
    add_row(mk_instr(OP_OTHER, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1),
            1'b0, '{default: '0});
    // A new body with start and last on the same item: tracking starts over
    // first, so nothing is found even though r31 held a constant.
    add_row(mk_instr(OP_STW, 0, 0, 3, 31, 0, 0, 0, 0, 1, 1),
            1'b1, '{found_pointer: 32'h0, final_res: 1'b1});

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_instr(directed_rows[i].instr, directed_rows[i].fixed, directed_rows[i].fixed_res);
    end

    // Random part: instruction bodies of random length, each opened with a
    // start request and closed with last, in phases of different idling.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      send_idle_pct  = send_idle_of_phase[phase];
      recv_stall_pct = recv_stall_of_phase[phase];
      sent = 0;
      while (sent < RANDOM_PER_PHASE) begin
        body_len = $urandom_range(30, 4);
        for (int k = 0; k < body_len; k++) begin
          send_instr(random_instr(k == 0, k == body_len - 1), 1'b0, '{default: '0});
        end
        sent += body_len;
      end
    end

    item_ch.valid <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
